>>> rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants for the priority disk dilation core
// Colour class codes, register indexes, configuration and control structs,
// and the small colour helper functions.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// colour class codes held in the class store
	localparam logic [2:0] CLS_WHITE  = 3'd0;
	localparam logic [2:0] CLS_BLACK  = 3'd1;
	localparam logic [2:0] CLS_RED    = 3'd2;
	localparam logic [2:0] CLS_BLUE   = 3'd3;
	localparam logic [2:0] CLS_GREEN  = 3'd4;
	localparam logic [2:0] CLS_YELLOW = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_IMG_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMG_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_RADIUS      = 3'd2;
	localparam logic [2:0] REG_RANK_BLACK  = 3'd3;
	localparam logic [2:0] REG_RANK_RED    = 3'd4;
	localparam logic [2:0] REG_RANK_BLUE   = 3'd5;
	localparam logic [2:0] REG_RANK_GREEN  = 3'd6;
	localparam logic [2:0] REG_RANK_YELLOW = 3'd7;

	// request kinds carried on tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_FETCH = 1'b1;

	localparam logic [7:0] CH_MAX = 8'd255;

	typedef struct packed {
		logic [8:0] img_width;
		logic [8:0] img_height;
		logic [3:0] radius;
		logic [2:0] rank_black;
		logic [2:0] rank_red;
		logic [2:0] rank_blue;
		logic [2:0] rank_green;
		logic [2:0] rank_yellow;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;        // latch the accepted item
		logic prep;        // wrap fetch pointer, start coordinate divide
		logic scan_init;   // set up the neighbourhood scan
		logic scan_step;   // visit one disk position
		logic load_write;  // store the class of a loaded pixel
		logic emit;        // move the result into the output register
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic is_fetch;
		logic scan_last;
		logic out_free;
	} dp_status_t;

	// exact colours only; everything else is white
	function automatic logic [2:0] classify(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [2:0] c;
		c = CLS_WHITE;
		if (r == '0 && g == '0 && b == '0)
			c = CLS_BLACK;
		else if (r == CH_MAX && g == '0 && b == '0)
			c = CLS_RED;
		else if (r == '0 && g == '0 && b == CH_MAX)
			c = CLS_BLUE;
		else if (r == '0 && g == CH_MAX && b == '0)
			c = CLS_GREEN;
		else if (r == CH_MAX && g == CH_MAX && b == '0)
			c = CLS_YELLOW;
		return c;
	endfunction

	function automatic logic [2:0] rank_of(input logic [2:0] cls, input cfg_t cfg);
		logic [2:0] rk;
		case (cls)
			CLS_BLACK:  rk = cfg.rank_black;
			CLS_RED:    rk = cfg.rank_red;
			CLS_BLUE:   rk = cfg.rank_blue;
			CLS_GREEN:  rk = cfg.rank_green;
			CLS_YELLOW: rk = cfg.rank_yellow;
			default:    rk = 3'd0;
		endcase
		return rk;
	endfunction

	// representative colour, packed {blue, green, red}
	function automatic logic [23:0] rep_colour(input logic [2:0] cls);
		logic [23:0] c;
		case (cls)
			CLS_BLACK:  c = {8'd0, 8'd0, 8'd0};
			CLS_RED:    c = {8'd0, 8'd0, CH_MAX};
			CLS_BLUE:   c = {CH_MAX, 8'd0, 8'd0};
			CLS_GREEN:  c = {8'd0, CH_MAX, 8'd0};
			CLS_YELLOW: c = {8'd0, CH_MAX, CH_MAX};
			default:    c = {CH_MAX, CH_MAX, CH_MAX};
		endcase
		return c;
	endfunction

endpackage

>>> rtl/priority_disk_dilation_core.sv
// ----------------------------------------------------------------------------
// priority_disk_dilation_core: colour-class image store with disk dilation
// Throughput: one item at a time, set by the shared divider and the single
// class store read port, one disk position per cycle during a fetch.
// Reset clears pointers, control and configuration registers to defaults; store is not cleared.
// ----------------------------------------------------------------------------
module priority_disk_dilation_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
	input  logic        s_axis_tuser,  // [0] req_type
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
	output logic        m_axis_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import pdd_pkg::*;

	cfg_t       cfg_q;
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_width   <= 9'd256;
			cfg_q.img_height  <= 9'd256;
			cfg_q.radius      <= 4'd1;
			cfg_q.rank_black  <= 3'd1;
			cfg_q.rank_red    <= 3'd2;
			cfg_q.rank_blue   <= 3'd3;
			cfg_q.rank_green  <= 3'd4;
			cfg_q.rank_yellow <= 3'd5;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMG_WIDTH:   cfg_q.img_width   <= cfg_data;
				REG_IMG_HEIGHT:  cfg_q.img_height  <= cfg_data;
				REG_RADIUS:      cfg_q.radius      <= cfg_data[3:0];
				REG_RANK_BLACK:  cfg_q.rank_black  <= cfg_data[2:0];
				REG_RANK_RED:    cfg_q.rank_red    <= cfg_data[2:0];
				REG_RANK_BLUE:   cfg_q.rank_blue   <= cfg_data[2:0];
				REG_RANK_GREEN:  cfg_q.rank_green  <= cfg_data[2:0];
				REG_RANK_YELLOW: cfg_q.rank_yellow <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	pdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

>>> rtl/pdd_div.sv
// ----------------------------------------------------------------------------
// pdd_div: iterative restoring divider
// Splits a raster index into row (quotient) and column (remainder), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdd_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	// trial subtract of the next partial remainder
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				done_q <= 1'b1;
		end
	end

	// quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < den_q)
		else $error("divider remainder not below divisor");

	a_done_after_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CNT_W'(1)) && !start |=> done_q)
		else $error("divider finished without done");

endmodule

>>> rtl/pdd_datapath.sv
// ----------------------------------------------------------------------------
// pdd_datapath: class store, pointers, neighbourhood scan and output register
// Holds the per-pixel class memory, walks the disk one position a cycle and
// keeps the best-ranked class found.
// ----------------------------------------------------------------------------
module pdd_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int MAX_RADIUS = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdd_pkg::cfg_t       cfg,
	input  pdd_pkg::ctrl_cmd_t  cmd,
	output pdd_pkg::dp_status_t sts,
	input  logic                in_user,
	input  logic [23:0]         in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         out_data,
	output logic                out_last
);
	import pdd_pkg::*;

	localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RB  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
	localparam int DW  = RB + 1;
	localparam int SQW = 2 * RB + 1;
	localparam int MW  = (XW > YW) ? XW : YW;
	localparam int NW  = ((MW > RB) ? MW : RB) + 2;
	localparam int AW  = XW + YW;

	// effective configuration
	logic [WW-1:0]        w_eff;
	logic [HW-1:0]        h_eff;
	logic [RB-1:0]        r_eff;
	logic [PW-1:0]        size_q;

	// item and pointer state
	logic                 fetch_q;
	logic [2:0]           cls_q;
	logic [PW-1:0]        load_ptr_q;
	logic [PW-1:0]        fetch_ptr_q;
	logic [PW-1:0]        fetch_wrap;

	// divider
	logic [PW-1:0]        div_quot;
	logic [WW-1:0]        div_rem;
	logic                 div_done;
	logic [XW-1:0]        cx;
	logic [YW-1:0]        cy;

	// scan
	logic signed [DW-1:0] dx_q;
	logic signed [DW-1:0] dy_q;
	logic signed [DW-1:0] r_pos;
	logic signed [DW-1:0] r_neg;
	logic [RB-1:0]        adx;
	logic [RB-1:0]        ady;
	logic [SQW-1:0]       dist2;
	logic [SQW-1:0]       r2;
	logic signed [NW-1:0] nx;
	logic signed [NW-1:0] ny;
	logic                 hit;
	logic [AW-1:0]        rd_addr;
	logic [2:0]           rd_cls_s1;
	logic                 hit_s1;
	logic [2:0]           rd_rank;
	logic [2:0]           best_rank_q;
	logic [2:0]           best_cls_q;

	// output register
	logic                 out_valid_q;
	logic [23:0]          out_data_q;
	logic                 out_last_q;

	logic [2:0]           store [2**AW];

	// size and radius clamping
	always_comb begin
		if (cfg.img_width == '0)
			w_eff = WW'(1);
		else if (32'(cfg.img_width) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(cfg.img_width);

		if (cfg.img_height == '0)
			h_eff = HW'(1);
		else if (32'(cfg.img_height) > MAX_HEIGHT)
			h_eff = HW'(MAX_HEIGHT);
		else
			h_eff = HW'(cfg.img_height);

		if (32'(cfg.radius) > MAX_RADIUS)
			r_eff = RB'(MAX_RADIUS);
		else
			r_eff = RB'(cfg.radius);
	end

	// image size, one multiply registered
	always_ff @(posedge clk) begin
		size_q <= PW'(w_eff) * PW'(h_eff);
	end

	// latch the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fetch_q <= REQ_LOAD;
		else if (cmd.take)
			fetch_q <= in_user;
	end

	always_ff @(posedge clk) begin
		if (cmd.take)
			cls_q <= classify(in_data[7:0], in_data[15:8], in_data[23:16]);
	end

	// fetch restarts at pixel 0 when it lies beyond the image
	assign fetch_wrap = (fetch_ptr_q >= size_q) ? '0 : fetch_ptr_q;

	// raster pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q  <= '0;
			fetch_ptr_q <= '0;
		end else if (cmd.prep && fetch_q) begin
			fetch_ptr_q <= fetch_wrap;
		end else if (cmd.load_write && load_ptr_q < size_q) begin
			load_ptr_q <= load_ptr_q + 1'b1;
		end else if (cmd.emit) begin
			if (fetch_ptr_q == size_q - 1'b1) begin
				fetch_ptr_q <= '0;
				load_ptr_q  <= '0;
			end else begin
				fetch_ptr_q <= fetch_ptr_q + 1'b1;
			end
		end
	end

	// raster index to column and row
	pdd_div #(
		.NUM_W (PW),
		.DEN_W (WW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.prep),
		.numer  (fetch_q ? fetch_wrap : load_ptr_q),
		.denom  (w_eff),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign cx = div_rem[XW-1:0];
	assign cy = div_quot[YW-1:0];

	// scan position counters, raster order over the square
	assign r_pos = $signed(DW'(r_eff));
	assign r_neg = -r_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q <= '0;
			dy_q <= '0;
		end else if (cmd.scan_init) begin
			dx_q <= r_neg;
			dy_q <= r_neg;
		end else if (cmd.scan_step) begin
			if (dx_q == r_pos) begin
				dx_q <= r_neg;
				dy_q <= dy_q + 1'b1;
			end else begin
				dx_q <= dx_q + 1'b1;
			end
		end
	end

	// disk membership and border clipping
	always_comb begin
		adx     = dx_q[DW-1] ? RB'(-dx_q) : RB'(dx_q);
		ady     = dy_q[DW-1] ? RB'(-dy_q) : RB'(dy_q);
		dist2   = SQW'(adx * adx) + SQW'(ady * ady);
		r2      = SQW'(r_eff * r_eff);
		nx      = $signed(NW'(cx)) + NW'(dx_q);
		ny      = $signed(NW'(cy)) + NW'(dy_q);
		hit     = cmd.scan_step && (dist2 <= r2)
			&& !nx[NW-1] && (nx < $signed(NW'(w_eff)))
			&& !ny[NW-1] && (ny < $signed(NW'(h_eff)));
		rd_addr = {ny[YW-1:0], nx[XW-1:0]};
	end

	// class store write port
	always_ff @(posedge clk) begin
		if (cmd.load_write && load_ptr_q < size_q)
			store[{cy, cx}] <= cls_q;
	end

	// class store read port
	always_ff @(posedge clk) begin
		rd_cls_s1 <= store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_s1 <= 1'b0;
		else
			hit_s1 <= hit;
	end

	// best rank; strict compare keeps the first in raster order on ties
	assign rd_rank = rank_of(rd_cls_s1, cfg);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_rank_q <= '0;
			best_cls_q  <= CLS_WHITE;
		end else if (hit_s1 && rd_rank > best_rank_q) begin
			best_rank_q <= rd_rank;
			best_cls_q  <= rd_cls_s1;
		end
	end

	// output register, refilled as the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= rep_colour(best_cls_q);
			out_last_q <= fetch_ptr_q == size_q - 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	assign sts.div_done  = div_done;
	assign sts.is_fetch  = fetch_q;
	assign sts.scan_last = (dx_q == r_pos) && (dy_q == r_pos);
	assign sts.out_free  = !out_valid_q || out_ready;

	a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_valid_q || out_ready)
		else $error("result emitted over an untaken result");

	a_read_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> $past(cmd.scan_step))
		else $error("store read valid without a scan step");

	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !cmd.load_write && !cmd.emit)
		else $error("store write or emit during scan");

endmodule

>>> rtl/pdd_ctrl.sv
// ----------------------------------------------------------------------------
// pdd_ctrl: sequencing state machine
// Takes one item at a time, runs the coordinate divide, then either stores
// a loaded pixel or scans the disk and hands the result to the output.
// ----------------------------------------------------------------------------
module pdd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pdd_pkg::dp_status_t sts,
	output pdd_pkg::ctrl_cmd_t  cmd
);
	import pdd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					if (sts.is_fetch) begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load_write = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && sts.scan_last |=> state_q == ST_DRAIN)
		else $error("scan did not end after the last position");

	a_div_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !sts.div_done |=> state_q == ST_DIV)
		else $error("left divide before it finished");

	a_drain_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_EMIT)
		else $error("drain not followed by emit");

endmodule

>>> tb/sv/tb_priority_disk_dilation_core.sv
// ----------------------------------------------------------------------------
// tb_priority_disk_dilation_core: self-checking bench for the dilation core
// Loads small images through the input stream, fetches the dilated pixels and
// compares every output transfer, field by field, against a behavioural copy
// of the class store and disk scan held in the bench. A directed opening is
// followed by random images with random ranks, radii and sizes, including the
// size extremes, partial images and loads beyond the image.
// ----------------------------------------------------------------------------
module tb_priority_disk_dilation_core;
	import pdd_pkg::*;

	localparam int MAX_W      = 256;
	localparam int MAX_H      = 256;
	localparam int MAX_R      = 15;
	localparam int MAX_PIXELS = MAX_W * MAX_H;

	localparam int ITEMS       = 620;
	localparam int IDLE_WAIT   = 40;     // covers a load still in progress
	localparam int END_WAIT    = 60;
	localparam int CYCLE_LIMIT = 3000000;

	localparam logic [14:0] RANKS_DEFAULT = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
	localparam logic [14:0] RANKS_TIED    = {3'd2, 3'd2, 3'd2, 3'd2, 3'd0};

	// directed frames, {blue, green, red}
	localparam logic [23:0] DIRECTED_PIXELS [12] = '{
		24'h000000, 24'h0000FF, 24'hFF0000, 24'h00FF00, 24'h00FFFF, 24'hFFFFFF,
		24'h00FFFF, 24'h00FF00, 24'hFF0000, 24'h0000FF, 24'h000000, 24'h7F7F7F
	};

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} out_pixel_t;

	// behavioural copy of the core: class store, pointers, registers
	class dilation_checker;
		logic [8:0]  width_reg;
		logic [8:0]  height_reg;
		logic [3:0]  radius_reg;
		logic [2:0]  rank_of_class [8];
		bit   [2:0]  class_mem [MAX_PIXELS];
		bit          stored [MAX_PIXELS];
		int unsigned load_ptr;
		int unsigned fetch_ptr;
		out_pixel_t  pending_pixels [$];
		int          mismatches;

		function new();
			width_reg  = 9'd256;
			height_reg = 9'd256;
			radius_reg = 4'd1;
			foreach (rank_of_class[c])
				rank_of_class[c] = 3'd0;
			rank_of_class[CLS_BLACK]  = 3'd1;
			rank_of_class[CLS_RED]    = 3'd2;
			rank_of_class[CLS_BLUE]   = 3'd3;
			rank_of_class[CLS_GREEN]  = 3'd4;
			rank_of_class[CLS_YELLOW] = 3'd5;
			load_ptr   = 0;
			fetch_ptr  = 0;
			mismatches = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned maxv);
			if (v == 0)
				return 1;
			return (v > maxv) ? maxv : v;
		endfunction

		function int unsigned cols();
			return clamp(32'(width_reg), MAX_W);
		endfunction

		function int unsigned pixels();
			return cols() * clamp(32'(height_reg), MAX_H);
		endfunction

		// representative colour, {blue, green, red}
		function logic [23:0] tone(logic [2:0] cls);
			case (cls)
				CLS_BLACK:  return 24'h000000;
				CLS_RED:    return 24'h0000FF;
				CLS_BLUE:   return 24'hFF0000;
				CLS_GREEN:  return 24'h00FF00;
				CLS_YELLOW: return 24'h00FFFF;
				default:    return 24'hFFFFFF;
			endcase
		endfunction

		function logic [2:0] class_of(logic [23:0] rgb);
			for (int c = int'(CLS_BLACK); c <= int'(CLS_YELLOW); c++)
				if (rgb == tone(c[2:0]))
					return c[2:0];
			return CLS_WHITE;
		endfunction

		function void apply_reg(logic [2:0] idx, logic [8:0] val);
			case (idx)
				REG_IMG_WIDTH:   width_reg = val;
				REG_IMG_HEIGHT:  height_reg = val;
				REG_RADIUS:      radius_reg = val[3:0];
				REG_RANK_BLACK:  rank_of_class[CLS_BLACK] = val[2:0];
				REG_RANK_RED:    rank_of_class[CLS_RED] = val[2:0];
				REG_RANK_BLUE:   rank_of_class[CLS_BLUE] = val[2:0];
				REG_RANK_GREEN:  rank_of_class[CLS_GREEN] = val[2:0];
				REG_RANK_YELLOW: rank_of_class[CLS_YELLOW] = val[2:0];
				default: ;
			endcase
		endfunction

		// a pointer left beyond a shrunk image restarts at pixel 0
		function int unsigned fetch_pos();
			return (fetch_ptr >= pixels()) ? 0 : fetch_ptr;
		endfunction

		// disk scan around the next fetch; also tells whether every
		// neighbour read has been written at some point
		function void scan_disk(output logic [2:0] winner, output bit defined);
			int w, h, r, cx, cy, nx, ny, dx, dy;
			logic [2:0] cls;
			logic [2:0] best_rank;
			w = cols();
			h = pixels() / cols();
			r = (int'(radius_reg) > MAX_R) ? MAX_R : int'(radius_reg);
			cx = fetch_pos() % w;
			cy = fetch_pos() / w;
			winner = CLS_WHITE;
			best_rank = 3'd0;
			defined = 1'b1;
			for (dy = -r; dy <= r; dy++) begin
				for (dx = -r; dx <= r; dx++) begin
					nx = cx + dx;
					ny = cy + dy;
					if (dx * dx + dy * dy <= r * r && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
						cls = class_mem[ny * MAX_W + nx];
						if (!stored[ny * MAX_W + nx])
							defined = 1'b0;
						// strict compare: the first of equal ranks in raster order wins
						if (rank_of_class[cls] > best_rank) begin
							best_rank = rank_of_class[cls];
							winner = cls;
						end
					end
				end
			end
		endfunction

		function void note_request(logic req, logic [23:0] rgb);
			int unsigned idx, pos;
			logic [2:0] winner;
			bit defined;
			logic [23:0] colour;
			out_pixel_t px;
			if (req == REQ_LOAD) begin
				// loads past the end of the image are dropped
				if (load_ptr < pixels()) begin
					idx = (load_ptr / cols()) * MAX_W + load_ptr % cols();
					class_mem[idx] = class_of(rgb);
					stored[idx] = 1'b1;
					load_ptr++;
				end
			end else begin
				pos = fetch_pos();
				scan_disk(winner, defined);
				colour = tone(winner);
				px.red = colour[7:0];
				px.green = colour[15:8];
				px.blue = colour[23:16];
				px.last = (pos == pixels() - 1);
				pending_pixels.push_back(px);
				if (px.last) begin
					fetch_ptr = 0;
					load_ptr = 0;
				end else begin
					fetch_ptr = pos + 1;
				end
			end
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_pixel(logic [23:0] data, logic last);
			out_pixel_t want;
			if (pending_pixels.size() == 0) begin
				report("output transfer with no pixel expected");
			end else begin
				want = pending_pixels.pop_front();
				if (data[7:0] !== want.red)
					report($sformatf("out_red %0d, expected %0d", data[7:0], want.red));
				if (data[15:8] !== want.green)
					report($sformatf("out_green %0d, expected %0d", data[15:8], want.green));
				if (data[23:16] !== want.blue)
					report($sformatf("out_blue %0d, expected %0d", data[23:16], want.blue));
				if (last !== want.last)
					report($sformatf("last_pixel %0b, expected %0b", last, want.last));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // [7:0] in_red, [15:8] in_green, [23:16] in_blue
	logic        s_axis_tuser;  // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [8:0]  cfg_data;

	dilation_checker chk;
	int unsigned     items_done = 0;
	int unsigned     cycle_count = 0;
	bit              calm = 1'b0;
	bit              tx_gaps = 1'b1;
	bit              rx_stalls = 1'b1;

	priority_disk_dilation_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H),
		.MAX_RADIUS(MAX_R)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// output side: stalls in bursts, none once the run has calmed down
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (calm || !rx_stalls || $urandom_range(0, 5) != 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(posedge clk);
			end
		end
	end

	// output transfers, sampled at the edge that completes them
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			chk.check_pixel(m_axis_tdata, m_axis_tlast);
	end

	// mostly exact class colours, some near misses, some noise
	function automatic logic [23:0] random_rgb();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick <= 5)
			return chk.tone(pick[2:0]);
		if (pick == 6)
			return chk.tone(3'($urandom_range(0, 5))) ^ (24'd1 << $urandom_range(0, 23));
		return 24'($urandom);
	endfunction

	// one input transfer; tvalid is left high for the caller
	task automatic send(input logic req, input logic [23:0] rgb);
		bit counts;
		counts = (req == REQ_FETCH) || (chk.load_ptr < chk.pixels());
		if (!calm && tx_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rgb;
		s_axis_tuser  <= req;
		do @(posedge clk); while (!s_axis_tready);
		chk.note_request(req, rgb);
		if (counts)
			items_done++;
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		chk.apply_reg(idx, val);
	endtask

	// wait for the core to go quiet, then write every register
	task automatic configure(input logic [8:0] wreg, input logic [8:0] hreg,
			input logic [3:0] rad, input logic [14:0] ranks);
		logic [5:0] junk;
		s_axis_tvalid <= 1'b0;
		while (chk.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		cfg_write(REG_IMG_WIDTH, wreg);
		cfg_write(REG_IMG_HEIGHT, hreg);
		junk = 6'($urandom);
		cfg_write(REG_RADIUS, {junk[4:0], rad});
		for (int i = 0; i < 5; i++) begin
			junk = 6'($urandom);
			cfg_write(REG_RANK_BLACK + 3'(i), {junk, ranks[3 * i +: 3]});
		end
		cfg_valid <= 1'b0;
	endtask

	// loads and fetches interleaved at random; a fetch goes out only once
	// its whole neighbourhood has been written
	task automatic random_image(input logic [8:0] wreg, input logic [8:0] hreg,
			input logic [3:0] rad, input int unsigned fetch_pct, input int unsigned fetch_cap);
		logic [14:0] ranks;
		logic [2:0]  winner;
		int unsigned fetches;
		bit          done, can_load, can_fetch;
		for (int i = 0; i < 5; i++)
			ranks[3 * i +: 3] = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) :
				3'($urandom_range(1, 5));
		configure(wreg, hreg, rad, ranks);
		tx_gaps = ($urandom_range(0, 3) != 0);
		rx_stalls = ($urandom_range(0, 3) != 0);
		fetches = 0;
		done = 1'b0;
		while (!done) begin
			can_load = (chk.load_ptr < chk.pixels());
			chk.scan_disk(winner, can_fetch);
			if (!can_load && !can_fetch)
				break;
			// stray load past the end of the image
			if (!can_load && $urandom_range(0, 9) == 0)
				send(REQ_LOAD, random_rgb());
			if (can_fetch && (!can_load || $urandom_range(0, 99) < fetch_pct)) begin
				send(REQ_FETCH, 24'($urandom));
				fetches++;
				done = (chk.fetch_ptr == 0) || (fetches >= fetch_cap);
			end else begin
				send(REQ_LOAD, random_rgb());
			end
		end
		// image left unfinished: a 1x1 image wraps the fetch pointer and ends it
		if (chk.fetch_ptr != 0 || chk.load_ptr != 0)
			random_image(9'($urandom_range(0, 1)), 9'($urandom_range(0, 1)),
				4'($urandom), 50, 1);
	endtask

	initial begin
		int unsigned w, h, p, img;
		logic [3:0]  rad;
		chk = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_LOAD;
		cfg_valid = 1'b0;
		cfg_index = REG_IMG_WIDTH;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every class once, default ranks, then tied ranks with black disabled
		for (int f = 0; f < 2; f++) begin
			configure(9'd3, 9'd2, 4'd1, (f == 0) ? RANKS_DEFAULT : RANKS_TIED);
			for (int i = 0; i < 6; i++)
				send(REQ_LOAD, DIRECTED_PIXELS[6 * f + i]);
			for (int i = 0; i < 6; i++)
				send(REQ_FETCH, 24'h0);
		end

		img = 0;
		while (items_done < ITEMS) begin
			calm = (items_done >= ITEMS * 17 / 20);
			case (img)
				// full width, mostly loads, saturating width value at times
				2: random_image($urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)),
					9'd1, 4'($urandom_range(0, 2)), 2, 8);
				// full height on a zero width value
				5: random_image(9'd0, $urandom_range(0, 1) ? 9'd256 : 9'd511,
					4'($urandom_range(0, 2)), 40, 12);
				default: begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 6);
					p = $urandom_range(0, 9);
					if (p < 6) begin
						rad = 4'($urandom_range(0, 3));
					end else if (p < 8) begin
						rad = 4'($urandom_range(4, 7));
					end else begin
						// wide disks are slow, keep their images small
						rad = $urandom_range(0, 1) ? 4'd15 : 4'($urandom_range(8, 14));
						w = (w + 1) / 2;
						h = (h + 1) / 2;
					end
					random_image((w == 1 && $urandom_range(0, 2) == 0) ? 9'd0 : 9'(w),
						(h == 1 && $urandom_range(0, 2) == 0) ? 9'd0 : 9'(h),
						rad, $urandom_range(20, 60), 1000);
				end
			endcase
			img++;
		end

		calm = 1'b1;
		s_axis_tvalid <= 1'b0;
		while (chk.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (chk.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
